/* rtl/core/dfr_pkg.sv */
// dfr_pkg: shared types and constants of the delimited frame receiver.
// Used by every module under rtl/core; depends on nothing.

package dfr_pkg;

    // Field widths fixed by the interface
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 12;
    localparam int VERDICT_W = 3;
    localparam int LEN_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Request op codes on the input port
    localparam logic [OP_W-1:0] OP_RX    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_REARM = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CMD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LRC    = 2'd2;

    // Marker bytes
    localparam logic [BYTE_W-1:0] MARK_55 = 8'h55;
    localparam logic [BYTE_W-1:0] MARK_AA = 8'hAA;
    localparam logic [BYTE_W-1:0] MARK_7B = 8'h7B;
    localparam logic [BYTE_W-1:0] MARK_7D = 8'h7D;
    localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'h00;

    // Frame byte positions used by the verdict
    localparam int POS_ADDR = 0;
    localparam int POS_CMD  = 2;

    typedef enum logic [1:0] {
        CMD_RX,
        CMD_READ,
        CMD_REARM,
        CMD_NOP
    } cmd_kind_t;

    // Marker hunt state
    typedef enum logic [3:0] {
        HS_IDLE,
        HS_F55,
        HS_FAA,
        HS_F7B,
        HS_BODY,
        HS_S55,
        HS_SAA,
        HS_S7B,
        HS_S7D
    } hunt_t;

    // Verdict codes (an empty payload cannot occur once five bytes are stored)
    typedef enum logic [VERDICT_W-1:0] {
        V_OK    = 3'd0,
        V_SHORT = 3'd1,
        V_ADDR  = 3'd2,
        V_LRC   = 3'd4,
        V_CMD   = 3'd5
    } verdict_t;

    // Back-end sequencer
    typedef enum logic [2:0] {
        BK_WAIT,
        BK_EVAL,
        BK_WB,
        BK_J0,
        BK_J1,
        BK_J2,
        BK_READ,
        BK_EMIT
    } back_state_t;

    // Classified request held in the front queue
    typedef struct packed {
        cmd_kind_t            kind;
        logic [BYTE_W-1:0]    data;
        logic [INDEX_W-1:0]   index;
        logic                 in_range;
    } cmd_t;

    // One result
    typedef struct packed {
        logic                 frame_done;
        logic [VERDICT_W-1:0] verdict;
        logic [LEN_W-1:0]     payload_length;
        logic [BYTE_W-1:0]    read_data;
    } res_t;

endpackage

/* rtl/core/delimited_frame_receiver_lrc.sv */
// delimited_frame_receiver_lrc: top level of the framed receiver with LRC check.
// Depends on dfr_pkg, dfr_front, dfr_back and dfr_out.
//
// Requests enter through push/full: op 0 hands over one line byte, op 1 reads a
// stored buffer byte at read_index (payload from position 3), op 2 rearms the
// receiver and op 3 only reports status. Every request gives exactly one
// result, in order, on the empty/pop side: frame_done, verdict, payload_length
// and read_data describe the state just after that request.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes own_address,
// expected_command and check_lrc; write it only while no request is in flight.
// A two-entry request queue parts the input from the sequencer, and a result
// register parts it from the output, so either side may stall on its own.
// Steps per request in the sequencer: wait, evaluate and emit (which waits for a
// free result register) for most; a read adds a step for the registered buffer
// read; a broken marker adds a write-back step per written-back byte plus a
// re-evaluation; an end marker adds the steps J0, J1 and J2 for the buffer
// reads of the address and command bytes. A result shows on the output in the
// cycle after the sequencer pushes it.
// Reset empties both queues, clears the hunt state, count, sums and verdict and
// loads the config defaults; the buffer contents are not cleared.
// When pop stays low, the result is held and the request queue fills, then full.

module delimited_frame_receiver_lrc #(
    parameter int FRAME_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dfr_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic [dfr_pkg::OP_W-1:0]        op,
    input  logic [dfr_pkg::BYTE_W-1:0]      rx_byte,
    input  logic [dfr_pkg::INDEX_W-1:0]     read_index,
    output logic                            empty,
    input  logic                            pop,
    output logic                            frame_done,
    output logic [dfr_pkg::VERDICT_W-1:0]   verdict,
    output logic [dfr_pkg::LEN_W-1:0]       payload_length,
    output logic [dfr_pkg::BYTE_W-1:0]      read_data
);

    logic           cmd_valid;
    logic           cmd_pop;
    dfr_pkg::cmd_t  cmd;
    logic           out_ready;
    logic           res_push;
    dfr_pkg::res_t  res;

    dfr_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    dfr_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_ready (out_ready),
        .res_push  (res_push),
        .res       (res)
    );

    dfr_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_push       (res_push),
        .res            (res),
        .out_ready      (out_ready),
        .empty          (empty),
        .pop            (pop),
        .frame_done     (frame_done),
        .verdict        (verdict),
        .payload_length (payload_length),
        .read_data      (read_data)
    );

endmodule

/* rtl/core/dfr_front.sv */
// dfr_front: accepts requests, classifies them and queues them (two entries).
// Depends on dfr_pkg.

module dfr_front #(
    parameter int FRAME_BYTES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [dfr_pkg::OP_W-1:0]      op,
    input  logic [dfr_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [dfr_pkg::INDEX_W-1:0]   read_index,
    output logic                          cmd_valid,
    output dfr_pkg::cmd_t                 cmd,
    input  logic                          cmd_pop
);

    localparam int CW = $clog2(FRAME_BYTES) + 1;
    localparam int XW = (CW > dfr_pkg::INDEX_W) ? CW : dfr_pkg::INDEX_W;

    dfr_pkg::cmd_t  slot_reg [2];
    dfr_pkg::cmd_t  in_cmd;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push_ok, pop_ok;

    // Classify the incoming request
    always_comb
    begin
        in_cmd.data     = rx_byte;
        in_cmd.index    = read_index;
        in_cmd.in_range = (XW'(read_index) < XW'(FRAME_BYTES));
        unique case (op)
            dfr_pkg::OP_RX:    in_cmd.kind = dfr_pkg::CMD_RX;
            dfr_pkg::OP_READ:  in_cmd.kind = dfr_pkg::CMD_READ;
            dfr_pkg::OP_REARM: in_cmd.kind = dfr_pkg::CMD_REARM;
            dfr_pkg::OP_NOP:   in_cmd.kind = dfr_pkg::CMD_NOP;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && cmd_valid;

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

/* rtl/core/dfr_back.sv */
// dfr_back: marker hunt, frame buffer, write-back of broken markers and verdict.
// Depends on dfr_pkg; holds the frame buffer memory and the config registers.

module dfr_back #(
    parameter int FRAME_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dfr_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                            cmd_valid,
    input  dfr_pkg::cmd_t                   cmd,
    output logic                            cmd_pop,
    input  logic                            out_ready,
    output logic                            res_push,
    output dfr_pkg::res_t                   res
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = AW + 1;
    localparam int XW = (AW > dfr_pkg::INDEX_W) ? AW : dfr_pkg::INDEX_W;
    localparam int PW = (CW > dfr_pkg::LEN_W) ? CW : dfr_pkg::LEN_W;

    // Configuration
    logic [7:0]                 own_addr_reg;
    logic [6:0]                 exp_cmd_reg;
    logic                       check_lrc_reg;

    // Sequencer and frame state
    dfr_pkg::back_state_t       bk_state_reg, bk_state_next;
    dfr_pkg::cmd_t              cmd_reg, cmd_next;
    dfr_pkg::hunt_t             hunt_reg, hunt_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [7:0]                 last_reg, last_next;
    logic                       done_reg, done_next;
    dfr_pkg::verdict_t          verdict_reg, verdict_next;
    logic [1:0]                 wb_n_reg, wb_n_next;
    logic [1:0]                 wb_k_reg, wb_k_next;
    logic [7:0]                 wb_third_reg, wb_third_next;
    logic [7:0]                 addr0_reg, addr0_next;
    logic [7:0]                 rdata_reg, rdata_next;

    // Buffer memory
    logic [7:0]                 mem [FRAME_BYTES];
    logic [7:0]                 mem_rdata_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [AW-1:0]              mem_raddr;
    logic [XW-1:0]              idx_w;

    // Hunt evaluation of the current byte
    dfr_pkg::hunt_t             ev_hunt, ev_from;
    logic                       ev_ovf, ev_clear, ev_store, ev_judge;
    logic [1:0]                 ev_wb_n;
    logic [7:0]                 ev_third;
    logic                       rx_live;

    // Store unit
    logic [CW-1:0]              st_base_c, st_count;
    logic [7:0]                 st_base_s, st_byte, st_sum;
    logic                       st_in_buf;
    logic [7:0]                 wb_byte;
    logic                       wb_last;

    // Verdict and result
    dfr_pkg::verdict_t          judged;
    logic [PW-1:0]              len_w;

    assign idx_w   = XW'(cmd_reg.index);
    assign rx_live = (cmd_reg.kind == dfr_pkg::CMD_RX) && !done_reg;
    assign wb_last = (wb_k_reg == (wb_n_reg - 2'd1));

    // Write-back byte: 55, AA, then the third marker byte seen
    always_comb
    begin
        priority case (wb_k_reg)
            2'd0:    wb_byte = dfr_pkg::MARK_55;
            2'd1:    wb_byte = dfr_pkg::MARK_AA;
            default: wb_byte = wb_third_reg;
        endcase
    end

    // Marker hunt: a full buffer drops back to idle before the byte is looked at
    always_comb
    begin
        ev_ovf   = (count_reg >= CW'(FRAME_BYTES));
        ev_from  = ev_ovf ? dfr_pkg::HS_IDLE : hunt_reg;
        ev_hunt  = ev_from;
        ev_clear = 1'b0;
        ev_store = 1'b0;
        ev_judge = 1'b0;
        ev_wb_n  = 2'd0;
        ev_third = dfr_pkg::MARK_7B;
        unique case (ev_from)
            dfr_pkg::HS_IDLE:
                if (cmd_reg.data == dfr_pkg::MARK_55)
                    ev_hunt = dfr_pkg::HS_F55;
            dfr_pkg::HS_F55:
                ev_hunt = (cmd_reg.data == dfr_pkg::MARK_AA) ? dfr_pkg::HS_FAA
                                                             : dfr_pkg::HS_IDLE;
            dfr_pkg::HS_FAA:
                ev_hunt = (cmd_reg.data == dfr_pkg::MARK_7B) ? dfr_pkg::HS_F7B
                                                             : dfr_pkg::HS_IDLE;
            dfr_pkg::HS_F7B:
                if (cmd_reg.data == dfr_pkg::MARK_7B)
                begin
                    ev_hunt  = dfr_pkg::HS_BODY;
                    ev_clear = 1'b1;
                end
                else
                    ev_hunt = dfr_pkg::HS_IDLE;
            dfr_pkg::HS_BODY:
                if (cmd_reg.data == dfr_pkg::MARK_55)
                    ev_hunt = dfr_pkg::HS_S55;
                else
                    ev_store = 1'b1;
            dfr_pkg::HS_S55:
                if (cmd_reg.data == dfr_pkg::MARK_AA)
                    ev_hunt = dfr_pkg::HS_SAA;
                else
                    ev_wb_n = 2'd1;
            dfr_pkg::HS_SAA:
                if (cmd_reg.data == dfr_pkg::MARK_7D)
                    ev_hunt = dfr_pkg::HS_S7D;
                else if (cmd_reg.data == dfr_pkg::MARK_7B)
                    ev_hunt = dfr_pkg::HS_S7B;
                else
                    ev_wb_n = 2'd2;
            dfr_pkg::HS_S7B:
                if (cmd_reg.data == dfr_pkg::MARK_7B)
                begin
                    ev_hunt  = dfr_pkg::HS_BODY;
                    ev_clear = 1'b1;
                end
                else
                    ev_wb_n = 2'd3;
            dfr_pkg::HS_S7D:
                if (cmd_reg.data == dfr_pkg::MARK_7D)
                begin
                    ev_hunt  = dfr_pkg::HS_IDLE;
                    ev_judge = 1'b1;
                end
                else
                begin
                    ev_wb_n  = 2'd3;
                    ev_third = dfr_pkg::MARK_7D;
                end
            default:
                ev_hunt = dfr_pkg::HS_IDLE;
        endcase
    end

    // Store unit: buffer write, running sum from position three, count
    always_comb
    begin
        if (bk_state_reg == dfr_pkg::BK_WB)
        begin
            st_base_c = count_reg;
            st_base_s = sum_reg;
            st_byte   = wb_byte;
        end
        else
        begin
            st_base_c = ev_ovf ? '0 : count_reg;
            st_base_s = ev_ovf ? 8'd0 : sum_reg;
            st_byte   = cmd_reg.data;
        end
        st_in_buf = (st_base_c < CW'(FRAME_BYTES));
        st_count  = st_base_c + CW'(1);
        st_sum    = (st_base_c >= CW'(3)) ? (st_base_s + st_byte) : st_base_s;
    end

    // Verdict, checked in order
    always_comb
    begin
        priority if ((count_reg < CW'(5)) || (count_reg > CW'(FRAME_BYTES)))
            judged = dfr_pkg::V_SHORT;
        else if ((addr0_reg != own_addr_reg) && (addr0_reg != dfr_pkg::BROADCAST_ADDR))
            judged = dfr_pkg::V_ADDR;
        else if (check_lrc_reg && ((sum_reg - last_reg) != last_reg))
            judged = dfr_pkg::V_LRC;
        else if (mem_rdata_reg != {1'b1, exp_cmd_reg})
            judged = dfr_pkg::V_CMD;
        else
            judged = dfr_pkg::V_OK;
    end

    // Sequencer next state
    always_comb
    begin
        bk_state_next = bk_state_reg;
        unique case (bk_state_reg)
            dfr_pkg::BK_WAIT:
                if (cmd_valid)
                    bk_state_next = dfr_pkg::BK_EVAL;
            dfr_pkg::BK_EVAL:
                priority if (cmd_reg.kind == dfr_pkg::CMD_READ)
                    bk_state_next = dfr_pkg::BK_READ;
                else if (rx_live && ev_judge)
                    bk_state_next = dfr_pkg::BK_J0;
                else if (rx_live && (ev_wb_n != 2'd0))
                    bk_state_next = dfr_pkg::BK_WB;
                else
                    bk_state_next = dfr_pkg::BK_EMIT;
            dfr_pkg::BK_WB:
                if (wb_last)
                    bk_state_next = dfr_pkg::BK_EVAL;
            dfr_pkg::BK_J0:   bk_state_next = dfr_pkg::BK_J1;
            dfr_pkg::BK_J1:   bk_state_next = dfr_pkg::BK_J2;
            dfr_pkg::BK_J2:   bk_state_next = dfr_pkg::BK_EMIT;
            dfr_pkg::BK_READ: bk_state_next = dfr_pkg::BK_EMIT;
            dfr_pkg::BK_EMIT:
                if (out_ready)
                    bk_state_next = dfr_pkg::BK_WAIT;
            default:
                bk_state_next = dfr_pkg::BK_WAIT;
        endcase
    end

    // Sequencer outputs: queue pop, memory port, result push
    always_comb
    begin
        cmd_pop   = (bk_state_reg == dfr_pkg::BK_WAIT) && cmd_valid;
        res_push  = (bk_state_reg == dfr_pkg::BK_EMIT) && out_ready;
        mem_waddr = st_base_c[AW-1:0];
        mem_we    = st_in_buf &&
                    (((bk_state_reg == dfr_pkg::BK_EVAL) && rx_live && ev_store) ||
                     (bk_state_reg == dfr_pkg::BK_WB));
        unique case (bk_state_reg)
            dfr_pkg::BK_J0: mem_raddr = AW'(dfr_pkg::POS_ADDR);
            dfr_pkg::BK_J1: mem_raddr = AW'(dfr_pkg::POS_CMD);
            default:        mem_raddr = idx_w[AW-1:0];
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cmd_next      = cmd_reg;
        hunt_next     = hunt_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        done_next     = done_reg;
        verdict_next  = verdict_reg;
        wb_n_next     = wb_n_reg;
        wb_k_next     = wb_k_reg;
        wb_third_next = wb_third_reg;
        addr0_next    = addr0_reg;
        rdata_next    = rdata_reg;
        unique case (bk_state_reg)
            dfr_pkg::BK_WAIT:
                if (cmd_valid)
                    cmd_next = cmd;
            dfr_pkg::BK_EVAL:
            begin
                rdata_next = 8'd0;
                unique case (cmd_reg.kind)
                    dfr_pkg::CMD_RX:
                        if (!done_reg)
                        begin
                            hunt_next = ev_hunt;
                            if (ev_ovf || ev_clear)
                            begin
                                count_next = '0;
                                sum_next   = 8'd0;
                                last_next  = 8'd0;
                            end
                            if (ev_store)
                            begin
                                count_next = st_count;
                                sum_next   = st_sum;
                                last_next  = st_byte;
                            end
                            wb_n_next     = ev_wb_n;
                            wb_k_next     = 2'd0;
                            wb_third_next = ev_third;
                        end
                    dfr_pkg::CMD_REARM:
                    begin
                        hunt_next    = dfr_pkg::HS_IDLE;
                        count_next   = '0;
                        sum_next     = 8'd0;
                        last_next    = 8'd0;
                        done_next    = 1'b0;
                        verdict_next = dfr_pkg::V_OK;
                    end
                    dfr_pkg::CMD_READ,
                    dfr_pkg::CMD_NOP: ;
                endcase
            end
            dfr_pkg::BK_WB:
            begin
                count_next = st_count;
                sum_next   = st_sum;
                last_next  = st_byte;
                wb_k_next  = wb_k_reg + 2'd1;
                if (wb_last)
                    hunt_next = dfr_pkg::HS_BODY;
            end
            dfr_pkg::BK_J1:
                addr0_next = mem_rdata_reg;
            dfr_pkg::BK_J2:
            begin
                verdict_next = judged;
                done_next    = 1'b1;
            end
            dfr_pkg::BK_READ:
                rdata_next = cmd_reg.in_range ? mem_rdata_reg : 8'd0;
            dfr_pkg::BK_J0,
            dfr_pkg::BK_EMIT: ;
            default: ;
        endcase
    end

    // Result as seen after the request
    assign len_w = PW'(count_reg) - PW'(4);

    always_comb
    begin
        res.frame_done     = done_reg;
        res.verdict        = done_reg ? verdict_reg : 3'd0;
        res.payload_length = (done_reg && (count_reg >= CW'(4))) ? len_w[dfr_pkg::LEN_W-1:0]
                                                                 : '0;
        res.read_data      = rdata_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bk_state_reg <= dfr_pkg::BK_WAIT;
            hunt_reg     <= dfr_pkg::HS_IDLE;
            count_reg    <= '0;
            sum_reg      <= 8'd0;
            last_reg     <= 8'd0;
            done_reg     <= 1'b0;
            verdict_reg  <= dfr_pkg::V_OK;
            wb_n_reg     <= 2'd0;
            wb_k_reg     <= 2'd0;
        end
        else
        begin
            bk_state_reg <= bk_state_next;
            hunt_reg     <= hunt_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            last_reg     <= last_next;
            done_reg     <= done_next;
            verdict_reg  <= verdict_next;
            wb_n_reg     <= wb_n_next;
            wb_k_reg     <= wb_k_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        wb_third_reg <= wb_third_next;
        addr0_reg    <= addr0_next;
        rdata_reg    <= rdata_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg  <= 8'd0;
            exp_cmd_reg   <= 7'd0;
            check_lrc_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dfr_pkg::CFG_OWN_ADDRESS:  own_addr_reg  <= cfg_wdata;
                dfr_pkg::CFG_EXPECTED_CMD: exp_cmd_reg   <= cfg_wdata[6:0];
                dfr_pkg::CFG_CHECK_LRC:    check_lrc_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Frame buffer: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= st_byte;
        mem_rdata_reg <= mem[mem_raddr];
    end

endmodule

/* rtl/core/dfr_out.sv */
// dfr_out: one-entry result register that presents results as a queue head.
// Depends on dfr_pkg.

module dfr_out (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_push,
    input  dfr_pkg::res_t                   res,
    output logic                            out_ready,
    output logic                            empty,
    input  logic                            pop,
    output logic                            frame_done,
    output logic [dfr_pkg::VERDICT_W-1:0]   verdict,
    output logic [dfr_pkg::LEN_W-1:0]       payload_length,
    output logic [dfr_pkg::BYTE_W-1:0]      read_data
);

    dfr_pkg::res_t  res_reg;
    logic           empty_reg, empty_next;

    // Slot is free when empty or being taken this cycle
    assign out_ready = empty_reg || pop;
    assign empty     = empty_reg;

    always_comb
    begin
        priority if (res_push)
            empty_next = 1'b0;
        else if (pop)
            empty_next = 1'b1;
        else
            empty_next = empty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            empty_reg <= 1'b1;
        else
            empty_reg <= empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_reg <= res;
    end

    assign frame_done     = res_reg.frame_done;
    assign verdict        = res_reg.verdict;
    assign payload_length = res_reg.payload_length;
    assign read_data      = res_reg.read_data;

endmodule

/* rtl/core/dfr_checker.sv */
// dfr_checker: port-level checks on the frame receiver's result channel.
// Depends on dfr_pkg; bound to delimited_frame_receiver_lrc below.

module dfr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  logic                            pop,
    input  logic                            frame_done,
    input  logic [dfr_pkg::VERDICT_W-1:0]   verdict,
    input  logic [dfr_pkg::LEN_W-1:0]       payload_length,
    input  logic [dfr_pkg::BYTE_W-1:0]      read_data
);

    // No verdict or length is reported before a frame is closed
    a_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !frame_done) |-> (verdict == 3'd0 && payload_length == '0))
        else $error("status reported while no frame is done");

    // Only defined verdicts; an empty payload cannot pass the length check
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (verdict != 3'd3 && verdict != 3'd6 && verdict != 3'd7))
        else $error("undefined verdict code");

    // A waiting result stays until taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

    // A stalled result does not change
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(frame_done) && $stable(verdict) &&
                              $stable(payload_length) && $stable(read_data)))
        else $error("stalled result changed");

endmodule

bind delimited_frame_receiver_lrc dfr_checker u_dfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .frame_done     (frame_done),
    .verdict        (verdict),
    .payload_length (payload_length),
    .read_data      (read_data)
);

/* tb/dfr_tb_pkg.sv */
`timescale 1ns / 1ps
// dfr_tb_pkg: shadow of the frame receiver and the status checker for its bench.
// Depends on dfr_pkg for op codes, register indexes, hunt states, verdicts and res_t.

package dfr_tb_pkg;
    import dfr_pkg::*;

    localparam int FRAME_BYTES = 4096;
    // not in verdict_t: an empty payload cannot follow from five stored bytes
    localparam logic [VERDICT_W-1:0] V_EMPTY = 3'd3;
    localparam int MAX_REPORTS = 40;

    class receiver_shadow;
        // registers
        logic [BYTE_W-1:0]    own_address;
        logic [6:0]           expected_cmd;
        logic                 check_lrc;
        // hunt and frame state
        hunt_t                hunt;
        int unsigned          byte_count;
        logic [BYTE_W-1:0]    frame_store [FRAME_BYTES];
        bit                   ever_written [FRAME_BYTES];
        int unsigned          written_index [$];
        logic [BYTE_W-1:0]    payload_sum;
        logic [BYTE_W-1:0]    last_stored;
        bit                   done;
        logic [VERDICT_W-1:0] verdict;
        // status owed for each accepted request, oldest first
        res_t                 expected_status [$];
        // tallies
        int                   errors;
        int                   requests;
        int                   line_bytes;
        int                   reads;
        int                   rearms;
        int                   settings;
        int                   closed [8];

        function new();
            own_address = '0;
            expected_cmd = '0;
            check_lrc = 1'b1;
            hunt = HS_IDLE;
            clear_frame();
            done = 1'b0;
            verdict = V_OK;
            foreach (frame_store[i])
            begin
                frame_store[i] = '0;
                ever_written[i] = 1'b0;
            end
            foreach (closed[i])
                closed[i] = 0;
            errors = 0;
            requests = 0;
            line_bytes = 0;
            reads = 0;
            rearms = 0;
            settings = 0;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
            settings++;
            case (idx)
                CFG_OWN_ADDRESS:  own_address = value;
                CFG_EXPECTED_CMD: expected_cmd = value[6:0];
                CFG_CHECK_LRC:    check_lrc = value[0];
                default: ;
            endcase
        endfunction

        function void clear_frame();
            byte_count = 0;
            payload_sum = '0;
            last_stored = '0;
        endfunction

        // store one frame byte; past the buffer end nothing is stored, but count, sum and last byte move
        function void put_byte(logic [BYTE_W-1:0] b);
            if (byte_count < FRAME_BYTES)
            begin
                frame_store[byte_count] = b;
                if (!ever_written[byte_count])
                begin
                    ever_written[byte_count] = 1'b1;
                    written_index.push_back(byte_count);
                end
            end
            if (byte_count >= 3)
                payload_sum += b;
            last_stored = b;
            byte_count++;
        endfunction

        // checks in fixed order: length, address, payload, lrc, command
        function logic [VERDICT_W-1:0] judge();
            logic [BYTE_W-1:0] sum_wo_last;
            sum_wo_last = payload_sum - last_stored;
            if (byte_count < 5 || byte_count > FRAME_BYTES)
                return V_SHORT;
            if (frame_store[POS_ADDR] != own_address && frame_store[POS_ADDR] != BROADCAST_ADDR)
                return V_ADDR;
            if (byte_count == 4)
                return V_EMPTY;
            if (check_lrc && sum_wo_last != last_stored)
                return V_LRC;
            if (frame_store[POS_CMD] != {1'b1, expected_cmd})
                return V_CMD;
            return V_OK;
        endfunction

        // marker hunt; a broken marker is written back and the byte taken again
        function void take_byte(logic [BYTE_W-1:0] b);
            bit again;
            for (int pass = 0; pass < 2; pass++)
            begin
                again = 1'b0;
                if (done)
                    return;
                if (byte_count >= FRAME_BYTES)
                begin
                    clear_frame();
                    hunt = HS_IDLE;
                end
                case (hunt)
                    HS_IDLE:
                        if (b == MARK_55)
                            hunt = HS_F55;
                    HS_F55:
                        if (b == MARK_AA)
                            hunt = HS_FAA;
                        else
                            hunt = HS_IDLE;
                    HS_FAA:
                        if (b == MARK_7B)
                            hunt = HS_F7B;
                        else
                            hunt = HS_IDLE;
                    HS_F7B:
                        if (b == MARK_7B)
                        begin
                            hunt = HS_BODY;
                            clear_frame();
                        end
                        else
                            hunt = HS_IDLE;
                    HS_S55:
                        if (b == MARK_AA)
                            hunt = HS_SAA;
                        else
                        begin
                            put_byte(MARK_55);
                            hunt = HS_BODY;
                            again = 1'b1;
                        end
                    HS_SAA:
                        if (b == MARK_7D)
                            hunt = HS_S7D;
                        else if (b == MARK_7B)
                            hunt = HS_S7B;
                        else
                        begin
                            put_byte(MARK_55);
                            put_byte(MARK_AA);
                            hunt = HS_BODY;
                            again = 1'b1;
                        end
                    HS_S7B:
                        if (b == MARK_7B)
                        begin
                            hunt = HS_BODY;
                            clear_frame();
                        end
                        else
                        begin
                            put_byte(MARK_55);
                            put_byte(MARK_AA);
                            put_byte(MARK_7B);
                            hunt = HS_BODY;
                            again = 1'b1;
                        end
                    HS_S7D:
                        if (b == MARK_7D)
                        begin
                            hunt = HS_IDLE;
                            verdict = judge();
                            done = 1'b1;
                            closed[verdict]++;
                        end
                        else
                        begin
                            put_byte(MARK_55);
                            put_byte(MARK_AA);
                            put_byte(MARK_7D);
                            hunt = HS_BODY;
                            again = 1'b1;
                        end
                    HS_BODY:
                        if (b == MARK_55)
                            hunt = HS_S55;
                        else
                            put_byte(b);
                    default:
                        hunt = HS_IDLE;
                endcase
                if (!again)
                    return;
            end
        endfunction

        // accepted request: advance the shadow and queue the status it owes
        function void apply_request(logic [OP_W-1:0] kind, logic [BYTE_W-1:0] b,
                                    logic [INDEX_W-1:0] idx);
            res_t        st;
            int unsigned len;
            logic [BYTE_W-1:0] rd;
            rd = '0;
            requests++;
            case (kind)
                OP_RX:
                begin
                    line_bytes++;
                    take_byte(b);
                end
                OP_READ:
                begin
                    reads++;
                    if (idx < FRAME_BYTES)
                        rd = frame_store[idx];
                end
                OP_REARM:
                begin
                    rearms++;
                    hunt = HS_IDLE;
                    clear_frame();
                    done = 1'b0;
                    verdict = V_OK;
                end
                default: ;
            endcase
            len = (done && byte_count >= 4) ? byte_count - 4 : 0;
            st.frame_done = done;
            st.verdict = done ? verdict : '0;
            st.payload_length = len[LEN_W-1:0];
            st.read_data = rd;
            expected_status.push_back(st);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("t=%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, field, want, got);
            end
        endfunction

        function void check_status(res_t seen);
            res_t want;
            if (expected_status.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("t=%0t: result with no request outstanding, expected none, %s",
                             $time, $sformatf("actual done=%0d verdict=%0d length=%0d data=0x%0h",
                             seen.frame_done, seen.verdict, seen.payload_length,
                             seen.read_data));
                return;
            end
            want = expected_status.pop_front();
            compare_field("frame_done", want.frame_done, seen.frame_done);
            compare_field("verdict", want.verdict, seen.verdict);
            compare_field("payload_length", want.payload_length, seen.payload_length);
            compare_field("read_data", want.read_data, seen.read_data);
        endfunction
    endclass

endpackage

/* tb/delimited_frame_receiver_lrc_test.sv */
`timescale 1ns / 1ps
// delimited_frame_receiver_lrc_test: random and directed frames through the receiver,
// every status checked against a shadow. Depends on dfr_pkg, dfr_tb_pkg and the RTL.

module delimited_frame_receiver_lrc_test;
    import dfr_pkg::*;
    import dfr_tb_pkg::*;

    // slowest run is well under this: ~1.2k requests, a few long gaps and stalls,
    // one HOLD_CYCLES hold
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 12;
    localparam int PHASE_REQUESTS = 85;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_wdata;
    logic                 push;
    logic                 full;
    logic [OP_W-1:0]      op;
    logic [BYTE_W-1:0]    rx_byte;
    logic [INDEX_W-1:0]   read_index;
    logic                 empty;
    logic                 pop;
    logic                 frame_done;
    logic [VERDICT_W-1:0] verdict;
    logic [LEN_W-1:0]     payload_length;
    logic [BYTE_W-1:0]    read_data;

    receiver_shadow shadow;
    bit             sender_calm;
    bit             receiver_calm;
    int             pop_rate;
    bit             hold_pending;
    int             holds_done;
    int             cycles;

    delimited_frame_receiver_lrc #(
        .FRAME_BYTES(FRAME_BYTES)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .op             (op),
        .rx_byte        (rx_byte),
        .read_index     (read_index),
        .empty          (empty),
        .pop            (pop),
        .frame_done     (frame_done),
        .verdict        (verdict),
        .payload_length (payload_length),
        .read_data      (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end

    // both handshakes observed at the rising edge; results checked before new requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                shadow.check_status(res_t'{frame_done, verdict, payload_length, read_data});
            if (push && !full)
                shadow.apply_request(op, rx_byte, read_index);
        end
    end

    // result side: random pop, occasional long stalls, one long hold-off on request
    initial
    begin
        pop = 1'b0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                pop <= 1'b0;
                hold_pending = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else if (!receiver_calm && $urandom_range(0, 99) < 3)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(8, 40)) @(negedge clk);
            end
            else
                pop <= receiver_calm || ($urandom_range(0, 99) < pop_rate);
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom);
    endfunction

    // bytes biased towards the marker values
    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 4))
            0: return MARK_55;
            1: return MARK_AA;
            2: return MARK_7B;
            3: return MARK_7D;
            default: return rand_byte();
        endcase
    endfunction

    function automatic int sender_gap();
        int r;
        if (sender_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request and hold it until taken
    task automatic issue(logic [OP_W-1:0] kind, logic [BYTE_W-1:0] b,
                         logic [INDEX_W-1:0] idx);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        op <= kind;
        rx_byte <= b;
        read_index <= idx;
        do
            @(posedge clk);
        while (full);
    endtask

    // read back a position that has been written at some point; a no-op if none has been
    task automatic read_back();
        int n;
        n = shadow.written_index.size();
        if (n == 0)
            issue(OP_NOP, rand_byte(), rand_index());
        else
            issue(OP_READ, rand_byte(),
                  INDEX_W'(shadow.written_index[$urandom_range(0, n - 1)]));
    endtask

    // one line byte, now and then preceded by a read or a no-op
    task automatic line_byte(logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 99) < 6)
        begin
            if ($urandom_range(0, 1) == 0)
                read_back();
            else
                issue(OP_NOP, rand_byte(), rand_index());
        end
        issue(OP_RX, b, rand_index());
    endtask

    task automatic send_marker(logic [BYTE_W-1:0] tail);
        line_byte(MARK_55);
        line_byte(MARK_AA);
        line_byte(tail);
        line_byte(tail);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow.set_reg(idx, value);
    endtask

    // stop offering and wait until every status has come back
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed frame with random content, sometimes damaged
    task automatic send_frame();
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] lrc;
        logic [BYTE_W-1:0] brk;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] cmd;
        int                r;
        int                at;
        int                keep;
        // junk and partial markers ahead of the frame
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 4)) line_byte(noise_byte());
        send_marker(MARK_7B);
        // restart: a fresh start marker after some frame bytes
        if ($urandom_range(0, 99) < 6)
        begin
            repeat ($urandom_range(0, 6)) line_byte(rand_byte());
            send_marker(MARK_7B);
        end
        r = $urandom_range(0, 99);
        if (r < 85)
            repeat ($urandom_range(1, 10)) body.push_back(rand_byte());
        else if (r >= 92)
            repeat ($urandom_range(11, 40)) body.push_back(rand_byte());
        // partial marker inside the payload; written back, so it counts as data
        if ($urandom_range(0, 99) < 20)
        begin
            at = $urandom_range(0, body.size());
            keep = $urandom_range(1, 3);
            brk = rand_byte();
            if (brk == MARK_AA || brk == MARK_7B || brk == MARK_7D)
                brk ^= 8'h01;
            body.insert(at, brk);
            if (keep == 3)
                body.insert(at, ($urandom_range(0, 1) == 0) ? MARK_7B : MARK_7D);
            if (keep >= 2)
                body.insert(at, MARK_AA);
            body.insert(at, MARK_55);
        end
        lrc = '0;
        foreach (body[i])
            lrc += body[i];
        if ($urandom_range(0, 99) < 15)
            lrc += BYTE_W'($urandom_range(1, 255));
        body.push_back(lrc);
        r = $urandom_range(0, 99);
        addr = (r < 60) ? shadow.own_address : (r < 80) ? BROADCAST_ADDR : rand_byte();
        cmd = ($urandom_range(0, 99) < 85) ? {1'b1, shadow.expected_cmd} : rand_byte();
        body.push_front(cmd);
        body.push_front(rand_byte());
        body.push_front(addr);
        // truncated frames, too short to judge
        if ($urandom_range(0, 99) < 5)
        begin
            keep = $urandom_range(0, 3);
            while (body.size() > keep)
                void'(body.pop_back());
        end
        foreach (body[i])
            line_byte(body[i]);
        if ($urandom_range(0, 99) < 95)
            send_marker(MARK_7D);
        // bytes after the close are ignored until rearm
        repeat ($urandom_range(0, 2)) line_byte(noise_byte());
        if ($urandom_range(0, 99) < 30)
            read_back();
        issue(OP_REARM, rand_byte(), rand_index());
    endtask

    task automatic send_noise();
        repeat ($urandom_range(3, 12)) line_byte(noise_byte());
        if ($urandom_range(0, 99) < 30)
            issue(OP_REARM, rand_byte(), rand_index());
    endtask

    initial
    begin
        int          mark;
        int          r;
        logic [7:0]  own_val;
        logic [7:0]  cmd_val;
        logic [7:0]  lrc_val;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_OWN_ADDRESS;
        cfg_wdata = '0;
        push = 1'b0;
        op = OP_NOP;
        rx_byte = '0;
        read_index = '0;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        pop_rate = 70;
        hold_pending = 1'b0;
        shadow = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: good broadcast frame at reset settings, lrc sums to zero
        send_marker(MARK_7B);
        issue(OP_RX, 8'h00, 12'hFFF);
        issue(OP_RX, 8'hFF, 12'h000);
        issue(OP_RX, 8'h80, 12'hFFF);
        issue(OP_RX, 8'h01, 12'h000);
        issue(OP_RX, 8'hFF, 12'hFFF);
        issue(OP_RX, 8'h00, 12'h000);
        send_marker(MARK_7D);
        issue(OP_READ, 8'hFF, 12'h003);
        issue(OP_RX, 8'hFF, 12'hFFF);
        issue(OP_REARM, 8'hFF, 12'hFFF);
        issue(OP_NOP, 8'h00, 12'h000);
        // one byte between markers: too short
        send_marker(MARK_7B);
        issue(OP_RX, 8'h01, 12'h000);
        send_marker(MARK_7D);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    own_val = 8'h00;
                    cmd_val = 8'h00;
                    lrc_val = 8'h01;
                end
                1:
                begin
                    own_val = 8'hFF;
                    cmd_val = 8'h7F;
                    lrc_val = 8'h01;
                end
                2:
                begin
                    own_val = 8'h00;
                    cmd_val = 8'h7F;
                    lrc_val = 8'h00;
                end
                3:
                begin
                    own_val = 8'hFF;
                    cmd_val = 8'h00;
                    lrc_val = 8'h00;
                end
                default:
                begin
                    own_val = rand_byte();
                    cmd_val = 8'($urandom_range(0, 127));
                    lrc_val = 8'($urandom_range(0, 1));
                end
            endcase
            write_reg(CFG_OWN_ADDRESS, own_val);
            write_reg(CFG_EXPECTED_CMD, cmd_val);
            write_reg(CFG_CHECK_LRC, lrc_val);

            // pacing for this phase; phase 2 runs back to back
            sender_calm = (phase == 2) || ($urandom_range(0, 99) < 15);
            receiver_calm = (phase == 2) || ($urandom_range(0, 99) < 15);
            case ($urandom_range(0, 2))
                0: pop_rate = 90;
                1: pop_rate = 60;
                default: pop_rate = 30;
            endcase
            // receiver holds off while requests keep coming, filling the block
            if (phase == 1)
                hold_pending = 1'b1;

            mark = shadow.requests;
            while (shadow.requests - mark < PHASE_REQUESTS)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_frame();
                else if (r < 90)
                    send_noise();
                else if (r < 96)
                    read_back();
                else
                    issue(OP_REARM, rand_byte(), rand_index());
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("Run covered %0d requests: %0d line bytes, %0d reads, %0d rearms, %0d reg writes",
                 shadow.requests, shadow.line_bytes, shadow.reads, shadow.rearms,
                 shadow.settings);
        $display("Frames judged: ok %0d, short %0d, address %0d, lrc %0d, command %0d; %0d holds",
                 shadow.closed[V_OK], shadow.closed[V_SHORT], shadow.closed[V_ADDR],
                 shadow.closed[V_LRC], shadow.closed[V_CMD], holds_done);
        if (shadow.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
